/* sv/scpaf_pkg.sv */
// Shared codes, constants and lookup tables for the smartcard PPS/APDU framer.
package scpaf_pkg;

   // Operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_RX_BYTE  = 2'd0,
      OP_RESET    = 2'd1,
      OP_ARM_DATA = 2'd2,
      OP_IDLE     = 2'd3
   } op_type;

   // Event codes reported on the last result of a transaction
   typedef enum logic [2:0] {
      EVT_NONE       = 3'd0,
      EVT_HEADER     = 3'd1,
      EVT_PPS_OK     = 3'd2,
      EVT_PPS_DFLT   = 3'd3,
      EVT_DATA_DONE  = 3'd4,
      EVT_RESET_DONE = 3'd5
   } evt_type;

   localparam int ATR_BYTES_DEF  = 20;
   localparam int PPS_TABLE_SIZE = 15;

   localparam logic [7:0] PPS_START   = 8'hFF;
   localparam logic [7:0] PPS0_VALUE  = 8'h10;
   localparam logic [7:0] PPS_DFLT_1  = 8'h00;
   localparam logic [3:0] DIV_DEFAULT = 4'd2;
   localparam logic [8:0] COUNT_MAX   = 9'd511;

   // Answer-to-reset bytes; entries past the fixed twenty are zero
   function automatic logic [7:0] atr_byte(input logic [4:0] pos);
      logic [7:0] val;
      case (pos)
         5'd0:    val = 8'h3B;
         5'd1:    val = 8'h9D;
         5'd2:    val = 8'h96;
         5'd3:    val = 8'h80;
         5'd4:    val = 8'h1F;
         5'd5:    val = 8'hC6;
         5'd6:    val = 8'h43;
         5'd7:    val = 8'h43;
         5'd8:    val = 8'h20;
         5'd9:    val = 8'h42;
         5'd10:   val = 8'h6F;
         5'd11:   val = 8'h6F;
         5'd12:   val = 8'h74;
         5'd13:   val = 8'h6C;
         5'd14:   val = 8'h6F;
         5'd15:   val = 8'h61;
         5'd16:   val = 8'h64;
         5'd17:   val = 8'h65;
         5'd18:   val = 8'h72;
         5'd19:   val = 8'h55;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // PPS1:PCK keys; the table position plus one is the divisor
   function automatic logic [15:0] rate_key(input logic [3:0] pos);
      logic [15:0] val;
      case (pos)
         4'd0:    val = 16'h31DE;
         4'd1:    val = 16'h11FE;
         4'd2:    val = 16'h12FD;
         4'd3:    val = 16'h13FC;
         4'd4:    val = 16'h14FB;
         4'd5:    val = 16'h15FA;
         4'd6:    val = 16'h16F9;
         4'd7:    val = 16'h18F7;
         4'd8:    val = 16'h917E;
         4'd9:    val = 16'h927D;
         4'd10:   val = 16'h937C;
         4'd11:   val = 16'h947B;
         4'd12:   val = 16'h957A;
         4'd13:   val = 16'h9679;
         4'd14:   val = 16'h9778;
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

endpackage

/* sv/smartcard_pps_apdu_framer_core.sv */
// Card-side ISO 7816 T=0 framer: PPS handling, ATR send and APDU header capture.
// The first result of a transaction is offered in the cycle after acceptance.
// One transaction per cycle when it yields a single result and the result channel is ready;
// a PPS echo yields five results, a PPS default reply four and a reset request ATR_BYTES,
// emitted by the result sequencer at one result per cycle while the result channel is ready.
// Reset (synchronous, active high): idle state, zero count and length, divisor 2.
module smartcard_pps_apdu_framer_core
   import scpaf_pkg::*;
#(
   parameter int ATR_BYTES = ATR_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [7:0] rx_byte, [16:8] data_length, [23:17] zero
   input  logic [1:0]  req_tuser,  // [1:0] operation
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // [7:0] tx_byte, [11:8] baud_divisor,
                                   // [20:12] store_index, [28:21] hdr_class,
                                   // [36:29] hdr_instruction, [44:37] hdr_param1,
                                   // [52:45] hdr_param2, [60:53] hdr_length, [63:61] zero
   output logic        rsp_tlast,
   output logic [3:0]  rsp_tuser   // [0] tx_valid, [3:1] event_res
);

   localparam int BeatSpan = (ATR_BYTES > 5) ? ATR_BYTES : 5;
   localparam int BeatW    = $clog2(BeatSpan);
   localparam logic [BeatW-1:0] AtrLast = BeatW'(ATR_BYTES - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_HDR  = 2'd1,
      ST_DATA = 2'd2,
      ST_DONE = 2'd3
   } pstate_type;

   typedef enum logic [1:0] {
      KIND_SINGLE = 2'd0,
      KIND_ECHO   = 2'd1,
      KIND_DFLT   = 2'd2,
      KIND_ATR    = 2'd3
   } kind_type;

   // protocol state
   pstate_type       state_ff, state_in;
   logic [8:0]       count_ff, count_in;
   logic [8:0]       explen_ff, explen_in;
   logic [3:0]       div_ff, div_in;
   logic [4:0][7:0]  hb_ff;

   // result sequencer
   logic             busy_ff;
   logic [BeatW-1:0] beat_ff;
   kind_type         kind_ff, kind_in;
   evt_type          evt_ff, evt_in;
   logic [8:0]       idx_ff, idx_in;
   logic [3:0]       divpre_ff, divpre_in;
   logic [4:0][7:0]  hdr_ff, hdr_in;

   // request fields
   op_type           op;
   logic [7:0]       rx_byte;
   logic [8:0]       data_length;

   logic             req_acc;
   logic             hb_wr;
   logic [4:0][7:0]  hb_next;
   logic [8:0]       count_inc;
   logic             is_pps;
   logic             key_hit;
   logic [3:0]       key_pos;
   logic [15:0]      key;

   logic [BeatW-1:0] last_beat;
   logic             beat_last;
   logic [7:0]       tx_byte;
   logic             tx_valid;

   assign op          = op_type'(req_tuser);
   assign rx_byte     = req_tdata[7:0];
   assign data_length = req_tdata[16:8];

   // sequencer frees up on the final result of the current transaction
   always_comb begin
      case (kind_ff)
         KIND_SINGLE: last_beat = '0;
         KIND_ECHO:   last_beat = BeatW'(4);
         KIND_DFLT:   last_beat = BeatW'(3);
         KIND_ATR:    last_beat = AtrLast;
         default:     last_beat = '0;
      endcase
   end

   assign beat_last  = (beat_ff == last_beat);
   assign req_tready = !busy_ff || (rsp_tready && beat_last);
   assign req_acc    = req_tvalid && req_tready;

   // header bytes as they stand after this received byte
   assign hb_wr     = (state_ff == ST_IDLE) && (count_ff < 9'd5);
   assign count_inc = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 9'd1;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         hb_next[i] = (hb_wr && (count_ff[2:0] == 3'(i))) ? rx_byte : hb_ff[i];
      end
   end

   assign is_pps = (state_ff == ST_IDLE) && (hb_next[0] == PPS_START) &&
                   ((count_inc == 9'd4) ||
                    ((hb_next[1] == 8'h00) && (count_inc == 9'd3)));

   // look up PPS1:PCK, first match wins
   assign key = {hb_next[2], hb_next[3]};
   always_comb begin
      key_hit = 1'b0;
      key_pos = '0;
      for (int i = PPS_TABLE_SIZE - 1; i >= 0; i--) begin
         if (rate_key(4'(i)) == key) begin
            key_hit = 1'b1;
            key_pos = 4'(i);
         end
      end
   end

   // next protocol state and the result burst for an accepted transaction
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      explen_in = explen_ff;
      div_in    = div_ff;
      kind_in   = KIND_SINGLE;
      evt_in    = EVT_NONE;
      idx_in    = '0;
      divpre_in = div_ff;
      hdr_in    = '0;
      case (op)
         OP_RESET: begin
            div_in    = DIV_DEFAULT;
            divpre_in = DIV_DEFAULT;
            state_in  = ST_IDLE;
            count_in  = '0;
            kind_in   = KIND_ATR;
            evt_in    = EVT_RESET_DONE;
         end
         OP_ARM_DATA: begin
            state_in  = ST_DATA;
            explen_in = data_length;
         end
         OP_IDLE: begin
            state_in = ST_IDLE;
            count_in = '0;
         end
         OP_RX_BYTE: begin
            idx_in   = count_ff;
            count_in = count_inc;
            if (is_pps) begin
               count_in = '0;
               if (hb_next[1] != PPS0_VALUE) begin
                  kind_in = KIND_DFLT;
                  evt_in  = EVT_PPS_DFLT;
                  div_in  = DIV_DEFAULT;
               end else if ((hb_next[0] ^ hb_next[1] ^ hb_next[2]) == hb_next[3]) begin
                  if (key_hit) begin
                     kind_in = KIND_ECHO;
                     evt_in  = EVT_PPS_OK;
                     div_in  = key_pos + 4'd1;
                  end else begin
                     kind_in = KIND_DFLT;
                     evt_in  = EVT_PPS_DFLT;
                     div_in  = DIV_DEFAULT;
                  end
               end
            end else if ((state_ff == ST_IDLE) && (count_inc == 9'd5)) begin
               state_in = ST_HDR;
               count_in = '0;
               evt_in   = EVT_HEADER;
               hdr_in   = hb_next;
            end else if ((state_ff == ST_DATA) && (count_inc == explen_ff)) begin
               state_in = ST_DONE;
               count_in = '0;
               evt_in   = EVT_DATA_DONE;
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // hold protocol state, header bytes and the result burst; advance per result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         explen_ff <= '0;
         div_ff    <= DIV_DEFAULT;
         busy_ff   <= 1'b0;
         beat_ff   <= '0;
      end else if (req_acc) begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         explen_ff <= explen_in;
         div_ff    <= div_in;
         busy_ff   <= 1'b1;
         beat_ff   <= '0;
      end else if (busy_ff && rsp_tready) begin
         if (beat_last) begin
            busy_ff <= 1'b0;
         end else begin
            beat_ff <= beat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff   <= kind_in;
         evt_ff    <= evt_in;
         idx_ff    <= idx_in;
         divpre_ff <= divpre_in;
         hdr_ff    <= hdr_in;
         if ((op == OP_RX_BYTE) && hb_wr) begin
            hb_ff[count_ff[2:0]] <= rx_byte;
         end
      end
   end

   // select the byte to transmit for the current result
   always_comb begin
      tx_byte  = '0;
      tx_valid = 1'b0;
      case (kind_ff)
         KIND_SINGLE: begin
            tx_valid = 1'b0;
         end
         KIND_ECHO: begin
            tx_valid = (beat_ff != '0);
            case (beat_ff)
               BeatW'(1): tx_byte = hb_ff[0];
               BeatW'(2): tx_byte = hb_ff[1];
               BeatW'(3): tx_byte = hb_ff[2];
               BeatW'(4): tx_byte = hb_ff[3];
               default:   tx_byte = '0;
            endcase
         end
         KIND_DFLT: begin
            tx_valid = (beat_ff != '0);
            case (beat_ff)
               BeatW'(1): tx_byte = PPS_START;
               BeatW'(2): tx_byte = PPS_DFLT_1;
               BeatW'(3): tx_byte = PPS_START;
               default:   tx_byte = '0;
            endcase
         end
         KIND_ATR: begin
            tx_valid = 1'b1;
            tx_byte  = atr_byte(5'(beat_ff));
         end
         default: begin
            tx_valid = 1'b0;
         end
      endcase
   end

   // drive the result channel
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = beat_last;
   assign rsp_tdata  = {3'b000, hdr_ff[4], hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0],
                        idx_ff, (beat_last ? div_ff : divpre_ff), tx_byte};
   assign rsp_tuser  = {(beat_last ? evt_ff : EVT_NONE), tx_valid};

endmodule

/* dv/tb_smartcard_pps_apdu_framer_core.sv */
// Self-checking testbench for the smartcard PPS / APDU header framer core.
`timescale 1ns / 100ps

module tb_smartcard_pps_apdu_framer_core;
   import scpaf_pkg::*;

   localparam int CLK_HALF       = 4;
   localparam int QUIET_LIMIT    = 2000;
   localparam int RANDOM_ITEMS   = 128;

   // Card-side protocol phases tracked by the predictor
   typedef enum logic [1:0] {
      PS_IDLE   = 2'd0,
      PS_HEADER = 2'd1,
      PS_DATA   = 2'd2,
      PS_DONE   = 2'd3
   } proto_state_type;

   // One result item as it leaves the block
   typedef struct packed {
      logic [7:0]      tx_byte;
      logic            tx_valid;
      logic            last;
      logic [3:0]      divisor;
      logic [2:0]      evt;
      logic [8:0]      store_index;
      logic [4:0][7:0] hdr;
   } framer_rsp_type;

   // Answer-to-reset sent by the card
   localparam logic [0:19][7:0] ATR_SEQ = {
      8'h3B, 8'h9D, 8'h96, 8'h80, 8'h1F, 8'hC6, 8'h43, 8'h43, 8'h20, 8'h42,
      8'h6F, 8'h6F, 8'h74, 8'h6C, 8'h6F, 8'h61, 8'h64, 8'h65, 8'h72, 8'h55
   };

   // Accepted PPS1:PCK pairs; position plus one is the new divisor
   localparam logic [0:PPS_TABLE_SIZE-1][15:0] RATE_MATCH = {
      16'h31DE, 16'h11FE, 16'h12FD, 16'h13FC, 16'h14FB,
      16'h15FA, 16'h16F9, 16'h18F7, 16'h917E, 16'h927D,
      16'h937C, 16'h947B, 16'h957A, 16'h9679, 16'h9778
   };

   // Predicts the framer's replies and checks them in order
   class framer_scoreboard;
      framer_rsp_type  pending_rsp[$];
      framer_rsp_type  burst[$];
      proto_state_type state;
      logic [8:0]      rx_count;
      logic [4:0][7:0] hdr_bytes;
      logic [8:0]      data_len;
      logic [3:0]      divisor;
      int              errors;
      int              n_results;
      int              n_evt[8];

      function new();
         state     = PS_IDLE;
         rx_count  = '0;
         hdr_bytes = '0;
         data_len  = '0;
         divisor   = DIV_DEFAULT;
         errors    = 0;
         n_results = 0;
         foreach (n_evt[i]) n_evt[i] = 0;
      endfunction

      function framer_rsp_type make_rsp(logic valid, logic [7:0] b, logic [8:0] idx);
         framer_rsp_type r;
         r             = '0;
         r.tx_valid    = valid;
         r.tx_byte     = valid ? b : 8'h00;
         r.divisor     = divisor;
         r.store_index = idx;
         return r;
      endfunction

      // Send FF 00 FF and fall back to the default divisor on the last byte
      function void add_default_reply(logic [8:0] idx);
         framer_rsp_type r;
         burst.push_back(make_rsp(1'b1, PPS_START, idx));
         burst.push_back(make_rsp(1'b1, PPS_DFLT_1, idx));
         divisor = DIV_DEFAULT;
         r       = make_rsp(1'b1, PPS_START, idx);
         r.evt   = EVT_PPS_DFLT;
         burst.push_back(r);
      endfunction

      // Resolve a complete PPS request held in the header bytes
      function void add_pps_reply(logic [8:0] idx);
         framer_rsp_type r;
         int             hit;
         hit = -1;
         if (hdr_bytes[1] != PPS0_VALUE) begin
            add_default_reply(idx);
            return;
         end
         // bad check byte: stay silent
         if ((hdr_bytes[0] ^ hdr_bytes[1] ^ hdr_bytes[2]) != hdr_bytes[3]) return;
         for (int i = 0; i < PPS_TABLE_SIZE; i++) begin
            if (hit < 0 && RATE_MATCH[i] == {hdr_bytes[2], hdr_bytes[3]}) hit = i;
         end
         if (hit < 0) begin
            add_default_reply(idx);
            return;
         end
         // echo the request; new divisor shows on the final echo byte
         for (int i = 0; i < 3; i++) burst.push_back(make_rsp(1'b1, hdr_bytes[i], idx));
         divisor = 4'(hit + 1);
         r       = make_rsp(1'b1, hdr_bytes[3], idx);
         r.evt   = EVT_PPS_OK;
         burst.push_back(r);
      endfunction

      // Note an accepted request and queue the results it must produce
      function void note_request(op_type op, logic [7:0] rx, logic [8:0] len);
         framer_rsp_type r;
         logic [8:0]     idx;
         logic           pps_seen;
         burst.delete();
         pps_seen = 1'b0;
         case (op)
            OP_RESET: begin
               divisor = DIV_DEFAULT;
               for (int i = 0; i < ATR_BYTES_DEF; i++) begin
                  burst.push_back(make_rsp(1'b1, (i < 20) ? ATR_SEQ[i] : 8'h00, '0));
               end
               r     = burst.pop_back();
               r.evt = EVT_RESET_DONE;
               burst.push_back(r);
               state    = PS_IDLE;
               rx_count = '0;
            end
            OP_ARM_DATA: begin
               state    = PS_DATA;
               data_len = len;
               burst.push_back(make_rsp(1'b0, 8'h00, '0));
            end
            OP_IDLE: begin
               state    = PS_IDLE;
               rx_count = '0;
               burst.push_back(make_rsp(1'b0, 8'h00, '0));
            end
            default: begin
               idx = rx_count;
               r   = make_rsp(1'b0, 8'h00, idx);
               if (state == PS_IDLE && idx < 5) hdr_bytes[idx] = rx;
               if (rx_count != COUNT_MAX) rx_count++;
               if (state == PS_IDLE) begin
                  pps_seen = hdr_bytes[0] == PPS_START &&
                             (rx_count == 4 || (rx_count == 3 && hdr_bytes[1] == PPS_DFLT_1));
                  if (pps_seen) begin
                     rx_count = '0;
                  end else if (rx_count == 5) begin
                     state    = PS_HEADER;
                     rx_count = '0;
                     r.evt    = EVT_HEADER;
                     r.hdr    = hdr_bytes;
                  end
               end else if (state == PS_DATA && rx_count == data_len) begin
                  state    = PS_DONE;
                  rx_count = '0;
                  r.evt    = EVT_DATA_DONE;
               end
               burst.push_back(r);
               if (pps_seen) add_pps_reply(idx);
            end
         endcase
         r      = burst.pop_back();
         r.last = 1'b1;
         burst.push_back(r);
         foreach (burst[i]) pending_rsp.push_back(burst[i]);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         end
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_response(framer_rsp_type act);
         framer_rsp_type exp_r;
         string          hdr_name[5] = '{"hdr_class", "hdr_instruction", "hdr_param1",
                                         "hdr_param2", "hdr_length"};
         n_results++;
         if (pending_rsp.size() == 0) begin
            errors++;
            $error("result arrived with nothing pending");
            return;
         end
         exp_r = pending_rsp.pop_front();
         n_evt[exp_r.evt]++;
         compare_field("tx_byte", 32'(exp_r.tx_byte), 32'(act.tx_byte));
         compare_field("tx_valid", 32'(exp_r.tx_valid), 32'(act.tx_valid));
         compare_field("last", 32'(exp_r.last), 32'(act.last));
         compare_field("baud_divisor", 32'(exp_r.divisor), 32'(act.divisor));
         compare_field("event_res", 32'(exp_r.evt), 32'(act.evt));
         compare_field("store_index", 32'(exp_r.store_index), 32'(act.store_index));
         for (int k = 0; k < 5; k++) begin
            compare_field(hdr_name[k], 32'(exp_r.hdr[k]), 32'(act.hdr[k]));
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [7:0] rx_byte, [16:8] data_length, [23:17] zero
   logic [1:0]  req_tuser  = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [7:0] tx_byte, [11:8] baud_divisor, [20:12] store_index,
                                   // [60:21] header bytes 0..4, [63:61] zero
   logic        rsp_tlast;
   logic [3:0]  rsp_tuser;         // [0] tx_valid, [3:1] event_res

   framer_scoreboard sb;
   int               max_gap = 10;
   int               n_req   = 0;
   int               quiet   = 0;

   smartcard_pps_apdu_framer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_req(op_type op, logic [7:0] rx, logic [8:0] len);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, len, rx};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      sb.note_request(op, rx, len);
      n_req++;
   endtask

   task automatic send_byte(logic [7:0] b);
      send_req(OP_RX_BYTE, b, 9'($urandom_range(1, 256)));
   endtask

   task automatic arm_data(logic [8:0] len);
      send_req(OP_ARM_DATA, 8'($urandom_range(0, 255)), len);
   endtask

   task automatic go_idle();
      send_req(OP_IDLE, 8'($urandom_range(0, 255)), 9'($urandom_range(1, 256)));
   endtask

   task automatic reset_card();
      send_req(OP_RESET, 8'($urandom_range(0, 255)), 9'($urandom_range(1, 256)));
   endtask

   // Return to idle only when the card is not already waiting for a fresh frame
   task automatic make_idle();
      if (sb.state != PS_IDLE || sb.rx_count != 9'd0) go_idle();
   endtask

   // PPS requests: mostly valid table entries, the rest short or broken
   task automatic pps_exchange();
      int         kind;
      int         k;
      logic [7:0] b1;
      logic [7:0] b2;
      make_idle();
      kind = $urandom_range(0, 9);
      k    = $urandom_range(0, PPS_TABLE_SIZE - 1);
      b1   = 8'($urandom_range(0, 255));
      b2   = 8'($urandom_range(0, 255));
      send_byte(PPS_START);
      case (kind)
         6: begin
            send_byte(PPS_DFLT_1);
            send_byte(b2);
         end
         7: begin
            send_byte(b1);
            send_byte(b2);
            if (b1 != PPS_DFLT_1) send_byte(8'($urandom_range(0, 255)));
         end
         8: begin
            send_byte(PPS0_VALUE);
            send_byte(b2);
            send_byte(PPS_START ^ PPS0_VALUE ^ b2 ^ 8'($urandom_range(1, 255)));
         end
         9: begin
            send_byte(PPS0_VALUE);
            send_byte(b2);
            send_byte(PPS_START ^ PPS0_VALUE ^ b2);
         end
         default: begin
            send_byte(PPS0_VALUE);
            send_byte(RATE_MATCH[k][15:8]);
            send_byte(RATE_MATCH[k][7:0]);
         end
      endcase
   endtask

   // APDU header, optional data phase of short length, optional return to idle
   task automatic apdu_exchange();
      int len;
      int n_data;
      make_idle();
      send_byte(8'($urandom_range(0, 254)));
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         arm_data(9'(len));
         case ($urandom_range(0, 3))
            0:       n_data = len - 1;
            1:       n_data = len + $urandom_range(1, 3);
            default: n_data = len;
         endcase
         repeat (n_data) send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) != 0) go_idle();
   endtask

   // Random operations in any state
   task automatic noise_burst();
      int pick;
      repeat ($urandom_range(1, 6)) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)       send_byte(8'($urandom_range(0, 255)));
         else if (pick == 6) arm_data(9'($urandom_range(1, 256)));
         else if (pick < 9)  go_idle();
         else                reset_card();
      end
   endtask

   // Full-length data phase of 256 bytes after a header
   task automatic long_count_run();
      make_idle();
      send_byte(8'h80);
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      arm_data(9'd256);
      repeat (256) send_byte(8'($urandom_range(0, 255)));
      go_idle();
   endtask

   // Result sink with random back-pressure
   initial begin : rsp_sink
      framer_rsp_type act;
      int             stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(0, max_gap);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         act             = '0;
         act.tx_byte     = rsp_tdata[7:0];
         act.divisor     = rsp_tdata[11:8];
         act.store_index = rsp_tdata[20:12];
         for (int k = 0; k < 5; k++) act.hdr[k] = rsp_tdata[21 + 8 * k +: 8];
         act.tx_valid    = rsp_tuser[0];
         act.evt         = rsp_tuser[3:1];
         act.last        = rsp_tlast;
         @(posedge clock);
         sb.check_response(act);
      end
   end

   // Watchdog: stop when no transaction moves for too long
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
         $display("no transaction for %0d cycles, %0d results pending",
                  QUIET_LIMIT, sb.pending_rsp.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      int rand_start;
      int pick;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: ATR, PPS at both table ends, short request, miss, bad check, header, data
      reset_card();
      send_byte(8'hFF); send_byte(8'h10); send_byte(8'h31); send_byte(8'hDE);
      send_byte(8'hFF); send_byte(8'h10); send_byte(8'h97); send_byte(8'h78);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'hA5);
      send_byte(8'hFF); send_byte(8'h10); send_byte(8'h20); send_byte(8'hCF);
      send_byte(8'hFF); send_byte(8'h10); send_byte(8'h11); send_byte(8'h00);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
      send_byte(8'hFF);
      arm_data(9'd1);
      send_byte(8'h5A);
      go_idle();

      max_gap = 1;
      long_count_run();

      // random: mostly well-formed exchanges, some noise, varying pace
      rand_start = n_req;
      while (n_req - rand_start < RANDOM_ITEMS) begin
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
         pick    = $urandom_range(0, 19);
         if (pick < 7)       pps_exchange();
         else if (pick < 14) apdu_exchange();
         else if (pick < 16) reset_card();
         else                noise_burst();
      end
      req_tvalid <= 1'b0;

      // drain, then leave room for anything unexpected
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Covered %0d requests, %0d results: %0d headers, %0d PPS echoes, %0d PPS defaults",
               n_req, sb.n_results, sb.n_evt[EVT_HEADER], sb.n_evt[EVT_PPS_OK],
               sb.n_evt[EVT_PPS_DFLT]);
      $display("%0d data phases completed, %0d answers-to-reset, %0d mismatches",
               sb.n_evt[EVT_DATA_DONE], sb.n_evt[EVT_RESET_DONE], sb.errors);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* smartcard_pps_apdu_framer_core.f */
sv/scpaf_pkg.sv
sv/smartcard_pps_apdu_framer_core.sv
dv/tb_smartcard_pps_apdu_framer_core.sv
